### rtl/lpfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
package lpfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 9;

  // Frame position codes; payload positions run from POS_PAYLOAD upward.
  localparam logic [POS_W-1:0] POS_IDLE    = 9'd0;
  localparam logic [POS_W-1:0] POS_TYPE    = 9'd1;
  localparam logic [POS_W-1:0] POS_LEN     = 9'd2;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd2;
  localparam logic [BYTE_W-1:0] MAX_LENGTH_RST = 8'd64;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] byte_offset;
    logic              is_last;
    logic              is_empty;
    logic              is_abort;
  } result_t;

endpackage

### rtl/lpfp_core.sv
// Frame state registers and the per-byte parse logic.
module lpfp_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [lpfp_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [lpfp_pkg::BYTE_W-1:0]   start_byte,
  input  logic [lpfp_pkg::BYTE_W-1:0]   max_length,
  output logic                          res_valid,
  output lpfp_pkg::result_t             res
);
  import lpfp_pkg::*;

  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  position_next;
  logic [POS_W-1:0]  end_position;
  logic [POS_W-1:0]  end_position_next;
  logic [BYTE_W-1:0] held_type;
  logic [BYTE_W-1:0] held_type_next;
  logic [POS_W-1:0]  pay_idx;
  logic [BYTE_W-1:0] idx;
  logic              room;

  assign pay_idx = position - POS_PAYLOAD;
  assign idx     = pay_idx[BYTE_W-1:0];
  // A non-final byte is kept only while index + 1 stays below max_length.
  assign room    = ({1'b0, idx} + 9'd1) < {1'b0, max_length};

  always_comb begin
    position_next     = position;
    end_position_next = end_position;
    held_type_next    = held_type;
    res_valid         = 1'b0;
    res.frame_type    = held_type;
    res.payload_byte  = '0;
    res.byte_offset   = '0;
    res.is_last       = 1'b0;
    res.is_empty      = 1'b0;
    res.is_abort      = 1'b0;
    if (position == POS_IDLE) begin
      if (rx_byte == start_byte) begin
        position_next = POS_TYPE;
      end
    end else if (position == POS_TYPE) begin
      held_type_next = rx_byte;
      position_next  = POS_LEN;
    end else if (position == POS_LEN) begin
      if (rx_byte == '0) begin
        position_next = POS_IDLE;
        res_valid     = 1'b1;
        res.is_last   = 1'b1;
        res.is_empty  = 1'b1;
      end else begin
        end_position_next = {1'b0, rx_byte} + POS_LEN;
        position_next     = POS_PAYLOAD;
      end
    end else begin
      res_valid       = 1'b1;
      res.byte_offset = idx;
      if ((position < end_position) && room) begin
        position_next    = position + 9'd1;
        res.payload_byte = rx_byte;
      end else if (position == end_position) begin
        position_next    = POS_IDLE;
        res.payload_byte = rx_byte;
        res.is_last      = 1'b1;
      end else begin
        position_next = POS_IDLE;
        res.is_abort  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= POS_IDLE;
      end_position <= '0;
      held_type    <= '0;
    end else if (step) begin
      position     <= position_next;
      end_position <= end_position_next;
      held_type    <= held_type_next;
    end
  end

endmodule

### rtl/lpfp_out_reg.sv
// Result register that holds one finished result until it is taken.
module lpfp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  lpfp_pkg::result_t  load_res,
  input  logic               take,
  output logic               valid,
  output lpfp_pkg::result_t  res
);
  import lpfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

### rtl/length_prefixed_frame_parser_unit.sv
// A byte's result reaches the master side via the input register, the parse logic
// and the result register. Throughput: one byte per cycle unless the master stalls;
// both registers advance together whenever the result register is free.
// While a result waits, one more byte can be taken into the input register.
// Reset (rst, synchronous, active high) returns the parser to idle, clears both
// stage valids and restores start_byte to 2 and max_length to 64.
module length_prefixed_frame_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // Slave side: tdata[7:0] = rx_byte.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,
  // Master side: tdata[7:0] = frame_type, [15:8] = payload_byte, [23:16] = byte_offset.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [23:0]                          m_tdata,
  output logic                                 m_tlast,
  // tuser[0] = is_empty, tuser[1] = is_abort.
  output logic [1:0]                           m_tuser,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [lpfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lpfp_pkg::BYTE_W-1:0]          cfg_data
);
  import lpfp_pkg::*;

  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] max_length;

  // Input register stage.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              out_free;

  logic              core_res_valid;
  result_t           core_res;
  result_t           out_res;

  // Configuration registers. A write takes effect from the next byte the
  // parser processes on.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      max_length <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE: start_byte <= cfg_data;
        REG_MAX_LENGTH: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register can take a new result when it is empty or being
  // drained this cycle. The held byte advances whenever that holds; a byte
  // that gives no result never needs the result register but waits the same.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  lpfp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (in_byte),
    .start_byte (start_byte),
    .max_length (max_length),
    .res_valid  (core_res_valid),
    .res        (core_res)
  );

  lpfp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && core_res_valid),
    .load_res (core_res),
    .take     (m_tready),
    .valid    (m_tvalid),
    .res      (out_res)
  );

  assign m_tdata = {out_res.byte_offset, out_res.payload_byte, out_res.frame_type};
  assign m_tlast = out_res.is_last;
  assign m_tuser = {out_res.is_abort, out_res.is_empty};

endmodule

### verif/tb_top.sv
// Self-checking testbench for the length-prefixed frame parser unit.
`timescale 1ns / 100ps

module tb_top;
  import lpfp_pkg::*;

  // Clock, reset and every block input start at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // rx_byte in bits [7:0].
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // frame_type [7:0], payload_byte [15:8], byte_offset [23:16].
  logic [23:0] m_tdata;
  logic        m_tlast;
  // is_empty [0], is_abort [1].
  logic [1:0]  m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START_BYTE;
  logic [BYTE_W-1:0]    cfg_data = 8'd0;

  length_prefixed_frame_parser_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the parser state and of its two registers.
  logic [POS_W-1:0]  frame_pos;
  logic [POS_W-1:0]  frame_end_pos;
  logic [BYTE_W-1:0] frame_type_held;
  logic [BYTE_W-1:0] start_byte_cfg;
  logic [BYTE_W-1:0] max_len_cfg;

  // Results the parser still owes us, oldest first.
  result_t frame_results_due[$];

  int  failures    = 0;
  int  bytes_sent  = 0;
  bit  gaps_on     = 1'b1;
  bit  stalls_on   = 1'b1;
  bit  hold_active = 1'b0;
  int  stall_left  = 0;

  // Advances the frame state by one received byte and queues the result it
  // produces, if any. This follows the parser's behavior bit for bit.
  task automatic parse_rx_byte(input logic [7:0] c);
    result_t          r;
    logic [POS_W-1:0] idx;
    r = '0;
    r.frame_type = frame_type_held;
    if (frame_pos == POS_IDLE) begin
      // Anything but the start value is line noise while idle.
      if (c == start_byte_cfg) frame_pos = POS_TYPE;
    end else if (frame_pos == POS_TYPE) begin
      frame_type_held = c;
      frame_pos = POS_LEN;
    end else if (frame_pos == POS_LEN) begin
      if (c == 8'd0) begin
        // A zero length closes the frame at once with an empty-frame result.
        frame_pos = POS_IDLE;
        r.is_last = 1'b1;
        r.is_empty = 1'b1;
        frame_results_due.push_back(r);
      end else begin
        frame_end_pos = {1'b0, c} + POS_LEN;
        frame_pos = POS_PAYLOAD;
      end
    end else begin
      idx = frame_pos - POS_PAYLOAD;
      r.byte_offset = idx[7:0];
      if (frame_pos < frame_end_pos && (idx + 9'd1) < {1'b0, max_len_cfg}) begin
        frame_pos = frame_pos + 9'd1;
        r.payload_byte = c;
      end else if (frame_pos == frame_end_pos) begin
        frame_pos = POS_IDLE;
        r.payload_byte = c;
        r.is_last = 1'b1;
      end else begin
        // Oversize frame: the byte is dropped and the frame is aborted.
        frame_pos = POS_IDLE;
        r.is_abort = 1'b1;
      end
      frame_results_due.push_back(r);
    end
  endtask

  // Offers one byte and returns once its transfer has happened. The valid is
  // left high so that back-to-back bytes follow without a gap; a random gap
  // lowers it first.
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // Stops offering bytes, waits for every owed result, then lets the pipe
  // settle, since ignored bytes may still be in flight with no result due.
  task automatic drain_parser();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Drains the parser, then writes both registers.
  task automatic set_config(input logic [7:0] start_val, input logic [7:0] max_len);
    drain_parser();
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_BYTE;
    cfg_data  <= start_val;
    @(posedge clk);
    start_byte_cfg = start_val;
    cfg_index <= REG_MAX_LENGTH;
    cfg_data  <= max_len;
    @(posedge clk);
    max_len_cfg = max_len;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A random byte that is guaranteed not to open a frame.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == start_byte_cfg) b = ~b;
    return b;
  endfunction

  // One frame with random content: mostly well formed and short, sometimes
  // empty, oversize, exactly at the length limit, long, or cut short.
  task automatic send_frame();
    int pick;
    int len;
    int sent_len;
    pick = $urandom_range(0, 15);
    repeat ($urandom_range(0, 2)) send_byte(noise_byte());
    if (pick == 0) begin
      len = 0;
    end else if (pick <= 2 && max_len_cfg < 32) begin
      len = max_len_cfg + $urandom_range(1, 3);
    end else if (pick == 3 && max_len_cfg < 32) begin
      len = max_len_cfg;
    end else if (pick == 4) begin
      len = $urandom_range(9, 40);
    end else begin
      len = $urandom_range(1, 8);
    end
    // A truncated frame swallows the next frame's header as payload.
    sent_len = (pick == 5) ? $urandom_range(0, len) : len;
    send_byte(start_byte_cfg);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'(len));
    repeat (sent_len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Holds the receiver off for as many cycles as its argument gives.
  task automatic hold_receiver(input int cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_active <= 1'b0;
  endtask

  // Receiver ready: random stall bursts, plus the long hold.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (hold_active) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      failures++;
    end
  endtask

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (frame_results_due.size() == 0) begin
        $error("unexpected result transfer: tdata=%h tlast=%b tuser=%b",
               m_tdata, m_tlast, m_tuser);
        failures++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("frame_type",   want.frame_type,   m_tdata[7:0]);
        check_field("payload_byte", want.payload_byte, m_tdata[15:8]);
        check_field("byte_offset",  want.byte_offset,  m_tdata[23:16]);
        check_field("is_last",      want.is_last,      m_tlast);
        check_field("is_empty",     want.is_empty,     m_tuser[0]);
        check_field("is_abort",     want.is_abort,     m_tuser[1]);
      end
    end
  end

  // Short frames at the reset settings: noise, an empty frame, a one-byte
  // frame, and a three-byte frame with the start value as type and payload.
  task automatic test_basic_frames();
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte(8'd3);
    send_byte(8'd2);
    send_byte(8'd0);
    send_byte(8'd0);
    send_byte(8'd2);
    send_byte(8'd255);
    send_byte(8'd1);
    send_byte(8'd255);
    send_byte(8'd2);
    send_byte(8'd2);
    send_byte(8'd3);
    send_byte(8'd2);
    send_byte(8'd0);
    send_byte(8'd255);
  endtask

  // Length limit: at a limit of one a single-byte frame passes and a longer
  // one aborts on its first byte; at three the third byte of five aborts.
  task automatic test_length_limit();
    set_config(8'd2, 8'd1);
    send_byte(8'd2);
    send_byte(8'h55);
    send_byte(8'd1);
    send_byte(8'h80);
    send_byte(8'd2);
    send_byte(8'h11);
    send_byte(8'd2);
    send_byte(8'h7f);
    set_config(8'd2, 8'd3);
    send_byte(8'd2);
    send_byte(8'h01);
    send_byte(8'd5);
    send_byte(8'haa);
    send_byte(8'hbb);
    send_byte(8'hcc);
  endtask

  // Start value extremes, and the longest frame accepted in full.
  task automatic test_start_extremes();
    set_config(8'd0, 8'd255);
    send_byte(8'd0);
    send_byte(8'h80);
    send_byte(8'd255);
    repeat (255) send_byte(8'($urandom_range(0, 255)));
    set_config(8'd255, 8'd255);
    send_byte(8'd0);
    send_byte(8'd254);
    send_byte(8'd255);
    send_byte(8'h01);
    send_byte(8'd2);
    send_byte(8'hff);
    send_byte(8'h00);
  endtask

  // The receiver stops for a long stretch while bytes keep coming, so the
  // parser fills up and has to refuse input until the receiver resumes.
  task automatic test_backpressure();
    set_config(8'($urandom_range(0, 255)), 8'd64);
    fork
      hold_receiver(300);
    join_none
    repeat (8) send_frame();
  endtask

  // Random frames over several register settings. The last phase runs with
  // no gaps and no stalls, at full throughput.
  task automatic test_random_frames();
    logic [7:0] limits[5];
    limits = '{8'd1, 8'd255, 8'($urandom_range(2, 16)), 8'd64,
               8'($urandom_range(1, 255))};
    foreach (limits[i]) begin
      set_config(8'($urandom_range(0, 255)), limits[i]);
      if (i == 4) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      bytes_sent = 0;
      while (bytes_sent < 320) send_frame();
    end
  endtask

  initial begin
    frame_pos       = POS_IDLE;
    frame_end_pos   = '0;
    frame_type_held = '0;
    start_byte_cfg  = START_BYTE_RST;
    max_len_cfg     = MAX_LENGTH_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_frames();
    test_length_limit();
    test_start_extremes();
    test_backpressure();
    test_random_frames();
    drain_parser();
    repeat (10) @(posedge clk);
    if (failures == 0 && frame_results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
rtl/lpfp_pkg.sv
rtl/lpfp_core.sv
rtl/lpfp_out_reg.sv
rtl/length_prefixed_frame_parser_unit.sv
verif/tb_top.sv
